### rtl/launch_and_deploy_detector_defines.svh
// Assertion macros shared by the launch and deploy detector RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef LAUNCH_AND_DEPLOY_DETECTOR_DEFINES_SVH
`define LAUNCH_AND_DEPLOY_DETECTOR_DEFINES_SVH
`ifndef SYNTH
`define LDD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ldd assertion failed");
`define LDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ldd assertion failed");
`else
`define LDD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LDD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/ldd_pkg.sv
// Shared widths, register indexes and types of the launch and deploy detector.
// No dependencies; imported by every RTL module of the block.
package ldd_pkg;

	localparam int ALT_W  = 24;
	localparam int ACC_W  = 20;
	localparam int TS_W   = 32;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_DEPLOY_ALTITUDE = 2'd0;
	localparam logic [IDX_W-1:0] REG_LAUNCH_ACCEL    = 2'd1;
	localparam logic [IDX_W-1:0] REG_HOLD_TIME       = 2'd2;

	localparam logic [TS_W-1:0] HOLD_TIME_RESET = 32'd1000;

	typedef struct packed {
		logic in_flight;
		logic deployed;
		logic deploy_signal;
	} flags_t;

endpackage

### rtl/ldd_cell.sv
// One window entry: holds an altitude and an acceleration sample.
// Depends on ldd_pkg; instantiated in a row by ldd_window.
module ldd_cell
	import ldd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  logic [ALT_W-1:0] alt_in,
	input  logic [ACC_W-1:0] acc_in,
	output logic [ALT_W-1:0] alt_out,
	output logic [ACC_W-1:0] acc_out
);

	logic [ALT_W-1:0] alt_q;
	logic [ACC_W-1:0] acc_q;

	// The window starts out as all zero samples, so the entries are cleared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_q <= '0;
			acc_q <= '0;
		end else if (shift) begin
			alt_q <= alt_in;
			acc_q <= acc_in;
		end
	end

	assign alt_out = alt_q;
	assign acc_out = acc_q;

endmodule

### rtl/ldd_window.sv
// Rolling windows as a shift line of cells, with running sums (stage one).
// Depends on ldd_pkg and ldd_cell.
module ldd_window
	import ldd_pkg::*;
#(
	parameter int WINDOW_SIZE = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         shift,
	input  logic [ALT_W-1:0]                             altitude,
	input  logic [ACC_W-1:0]                             net_accel,
	output logic signed [ALT_W+$clog2(WINDOW_SIZE)-1:0] alt_sum,
	output logic signed [ACC_W+$clog2(WINDOW_SIZE)-1:0] acc_sum
);

	localparam int ALT_SUM_W = ALT_W + $clog2(WINDOW_SIZE);
	localparam int ACC_SUM_W = ACC_W + $clog2(WINDOW_SIZE);

	logic [ALT_W-1:0] alt_chain [WINDOW_SIZE+1];
	logic [ACC_W-1:0] acc_chain [WINDOW_SIZE+1];

	logic signed [ALT_SUM_W-1:0] alt_sum_q;
	logic signed [ACC_SUM_W-1:0] acc_sum_q;

	assign alt_chain[0] = altitude;
	assign acc_chain[0] = net_accel;

	for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
		ldd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.alt_in  (alt_chain[i]),
			.acc_in  (acc_chain[i]),
			.alt_out (alt_chain[i+1]),
			.acc_out (acc_chain[i+1])
		);
	end

	// The last cell holds the sample that leaves the window on this beat.
	// The final sum always fits, so wrapping arithmetic at sum width is exact.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_sum_q <= '0;
			acc_sum_q <= '0;
		end else if (shift) begin
			alt_sum_q <= alt_sum_q + ALT_SUM_W'($signed(altitude))
				- ALT_SUM_W'($signed(alt_chain[WINDOW_SIZE]));
			acc_sum_q <= acc_sum_q + ACC_SUM_W'($signed(net_accel))
				- ACC_SUM_W'($signed(acc_chain[WINDOW_SIZE]));
		end
	end

	assign alt_sum = alt_sum_q;
	assign acc_sum = acc_sum_q;

endmodule

### rtl/ldd_flight.sv
// Flight phase logic: launch, deployment and the timed deploy signal (stage two).
// Depends on ldd_pkg and the assertion macros header.
`include "launch_and_deploy_detector_defines.svh"
module ldd_flight
	import ldd_pkg::*;
#(
	parameter int WINDOW_SIZE = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         step,
	input  logic signed [ALT_W+$clog2(WINDOW_SIZE)-1:0] alt_sum,
	input  logic signed [ACC_W+$clog2(WINDOW_SIZE)-1:0] acc_sum,
	input  logic signed [ALT_W+$clog2(WINDOW_SIZE)-1:0] alt_limit,
	input  logic signed [ACC_W+$clog2(WINDOW_SIZE)-1:0] acc_limit,
	input  logic [TS_W-1:0]                              hold_time,
	input  logic [TS_W-1:0]                              timestamp,
	output flags_t                                       flags
);

	logic            flight_q;
	logic            deploy_q;
	logic            level_q;
	logic [TS_W-1:0] elapsed_q;
	logic [TS_W-1:0] last_q;

	logic [TS_W-1:0] delta;
	logic [TS_W:0]   elapsed_sum;
	logic [TS_W-1:0] elapsed_next;

	// Stamp differences wrap, so a stamp going back counts as a long step.
	assign delta        = timestamp - last_q;
	assign elapsed_sum  = {1'b0, elapsed_q} + {1'b0, delta};
	assign elapsed_next = elapsed_sum[TS_W] ? '1 : elapsed_sum[TS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flight_q  <= 1'b0;
			deploy_q  <= 1'b0;
			level_q   <= 1'b0;
			elapsed_q <= '0;
			last_q    <= '0;
		end else if (step) begin
			if (flight_q) begin
				if (!deploy_q) begin
					if (alt_sum < alt_limit) begin
						deploy_q <= 1'b1;
						level_q  <= 1'b1;
						last_q   <= timestamp;
					end
				end else if (level_q) begin
					elapsed_q <= elapsed_next;
					last_q    <= timestamp;
					if (elapsed_next >= hold_time) begin
						level_q <= 1'b0;
					end
				end
			end else if (acc_sum > acc_limit) begin
				flight_q <= 1'b1;
			end
		end
	end

	assign flags.in_flight     = flight_q;
	assign flags.deployed      = deploy_q;
	assign flags.deploy_signal = level_q;

	`LDD_ASSERT_SAME(a_deploy_in_flight, clk, arst_n, deploy_q, flight_q)
	`LDD_ASSERT_SAME(a_level_deployed, clk, arst_n, level_q, deploy_q)
	`LDD_ASSERT_NEXT(a_deploy_sticks, clk, arst_n, deploy_q, deploy_q)
	`LDD_ASSERT_NEXT(a_elapsed_idle, clk, arst_n, !step, $stable(elapsed_q))

endmodule

### rtl/launch_and_deploy_detector.sv
// Launch and deploy detector: sample window with running sums and flight logic.
// The block takes one sample beat per cycle on a valid/ready input channel and
// returns one beat of three flags for each sample on a valid/ready output channel.
// A sample passes the window cells in the first stage, where the running
// altitude and acceleration sums are updated, and the flight logic in the second
// stage, whose flag registers are the output beat. An accepted input beat sets the
// stage-one valid register and its step sets the output valid register. While the
// receiver takes beats, a new sample is taken every cycle; the single running-sum
// update per beat sets that rate. When the receiver stalls, the output beat holds
// and the sample in the first stage waits; input ready stays high only while that
// stage is empty or can move on. Reset clears the windows, sums, flags and timer
// and sets the hold time to 1000 stamp units; there is no clearing pass, so input
// is taken right away. Thresholds are written over the APB port at 0x0 (altitude),
// 0x4 (accel) and 0x8 (hold time); the user must write them only while no beat is
// in flight, as the block does not enforce it. Scaled thresholds are registered.
module launch_and_deploy_detector
	import ldd_pkg::*;
#(
	parameter int WINDOW_SIZE = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ALT_W-1:0]  altitude,
	input  logic [ACC_W-1:0]  net_accel,
	input  logic [TS_W-1:0]   timestamp,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              in_flight,
	output logic              deployed,
	output logic              deploy_signal
);

	localparam int ALT_SUM_W = ALT_W + $clog2(WINDOW_SIZE);
	localparam int ACC_SUM_W = ACC_W + $clog2(WINDOW_SIZE);
	localparam logic signed [ALT_SUM_W:0] ALT_SCALE = (ALT_SUM_W+1)'(WINDOW_SIZE);
	localparam logic signed [ACC_SUM_W:0] ACC_SCALE = (ACC_SUM_W+1)'(WINDOW_SIZE);

	logic [ALT_W-1:0] deploy_altitude_q;
	logic [ACC_W-1:0] launch_accel_q;
	logic [TS_W-1:0]  hold_time_q;

	logic signed [ALT_SUM_W-1:0] alt_limit_q;
	logic signed [ACC_SUM_W-1:0] acc_limit_q;
	logic signed [ALT_SUM_W-1:0] alt_thr_ext;
	logic signed [ACC_SUM_W-1:0] acc_thr_ext;

	logic signed [ALT_SUM_W-1:0] alt_sum;
	logic signed [ACC_SUM_W-1:0] acc_sum;

	logic             cfg_write;
	logic [IDX_W-1:0] reg_idx;

	logic            valid_s1;
	logic [TS_W-1:0] ts_s1;
	logic            out_valid_q;
	logic            advance;
	logic            accept;
	logic            step;
	flags_t          flags;

	// Configuration port.
	assign pready    = 1'b1;
	assign reg_idx   = paddr[ADDR_W-1:ADDR_W-IDX_W];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deploy_altitude_q <= '0;
			launch_accel_q    <= '0;
			hold_time_q       <= HOLD_TIME_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_DEPLOY_ALTITUDE: deploy_altitude_q <= pwdata[ALT_W-1:0];
				REG_LAUNCH_ACCEL:    launch_accel_q    <= pwdata[ACC_W-1:0];
				REG_HOLD_TIME:       hold_time_q       <= pwdata[TS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DEPLOY_ALTITUDE: prdata = DATA_W'(deploy_altitude_q);
			REG_LAUNCH_ACCEL:    prdata = DATA_W'(launch_accel_q);
			REG_HOLD_TIME:       prdata = DATA_W'(hold_time_q);
			default:             prdata = '0;
		endcase
	end

	// Thresholds scaled by the window size, so sums compare without a divide.
	assign alt_thr_ext = ALT_SUM_W'($signed(deploy_altitude_q));
	assign acc_thr_ext = ACC_SUM_W'($signed(launch_accel_q));

	always_ff @(posedge clk) begin
		alt_limit_q <= ALT_SUM_W'(alt_thr_ext * ALT_SCALE);
		acc_limit_q <= ACC_SUM_W'(acc_thr_ext * ACC_SCALE);
	end

	// Pipeline control: stage two moves when the output beat is free or taken.
	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign accept    = in_valid && in_ready;
	assign step      = valid_s1 && advance;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ts_s1 <= timestamp;
		end
	end

	ldd_window #(
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift     (accept),
		.altitude  (altitude),
		.net_accel (net_accel),
		.alt_sum   (alt_sum),
		.acc_sum   (acc_sum)
	);

	ldd_flight #(
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_flight (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.alt_sum   (alt_sum),
		.acc_sum   (acc_sum),
		.alt_limit (alt_limit_q),
		.acc_limit (acc_limit_q),
		.hold_time (hold_time_q),
		.timestamp (ts_s1),
		.flags     (flags)
	);

	assign in_flight     = flags.in_flight;
	assign deployed      = flags.deployed;
	assign deploy_signal = flags.deploy_signal;

endmodule
